@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the audio frame store.
// No dependencies; take it in by a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/tarb_pkg.sv @@
// Shared types and constants for the timestamped audio frame store.
// No dependencies; imported by the top level, the remainder unit, the checker and the bench.
package tarb_pkg;

    localparam int TIME_BITS        = 48;
    localparam int FRAMES_BITS      = 13;
    localparam int INDEX_BITS       = 12;
    localparam int PORT_SAMPLE_BITS = 32;

    localparam int IN_TDATA_BITS    = 144;
    localparam int OUT_FIELD_BITS   = 2 + 2 * PORT_SAMPLE_BITS + 2 * TIME_BITS;
    localparam int OUT_TDATA_BITS   = 168;
    localparam int OUT_PAD_BITS     = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_MODT  = 13'b0000000001000,
        S_READ  = 13'b0000000010000,
        S_RDATA = 13'b0000000100000,
        S_BND1  = 13'b0000001000000,
        S_BND2  = 13'b0000010000000,
        S_GAPCK = 13'b0000100000000,
        S_MODG  = 13'b0001000000000,
        S_ZERO  = 13'b0010000000000,
        S_WRITE = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

endpackage

@@ rtl/core/tarb_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tarb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tarb_mod.sv @@
// Frame time to slot reduction: time modulo the store capacity.
// Depends on tarb_pkg; a mask for power-of-two capacity, else 4 bits a cycle.
module tarb_mod
    import tarb_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [TIME_BITS-1:0]        i_value,
    output logic                        o_done,
    output logic [$clog2(CAPACITY)-1:0] o_rem
);

    localparam int AW = $clog2(CAPACITY);

    generate
        if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
            logic          r_done;
            logic [AW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_rem <= i_value[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_iter
            localparam int STEP  = 4;
            localparam int NCYC  = TIME_BITS / STEP;
            localparam int CNT_W = $clog2(NCYC);
            localparam int RW    = AW + 1;
            localparam logic [RW-1:0] CAP_R = RW'(CAPACITY);

            logic                 r_busy;
            logic                 r_done;
            logic [CNT_W-1:0]     r_cnt;
            logic [TIME_BITS-1:0] r_val;
            logic [AW-1:0]        r_rem;
            logic [AW-1:0]        n_rem;
            logic [RW-1:0]        acc;

            // Shift in one bit and fold back below the capacity, four times.
            always_comb begin
                acc = RW'(r_rem);
                for (int k = 0; k < STEP; k++) begin
                    acc = {acc[RW-2:0], r_val[TIME_BITS-1-k]};
                    if (acc >= CAP_R) begin
                        acc = acc - CAP_R;
                    end
                end
                n_rem = acc[AW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(NCYC - 1);
                    end else if (r_busy) begin
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                end
                if (i_start) begin
                    r_val <= i_value;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_val <= r_val << STEP;
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

@@ rtl/core/timestamped_audio_ring_buffer.sv @@
// Channel    | Dir | Fields (tdata/tuser, lowest bit first)
// s_axis     | in  | tuser: cmd; tdata: request_start, request_frames, frame_index,
//            |     |        chan0_sample, chan1_sample
// m_axis     | out | tdata: ok, in_window, chan0_out, chan1_out, window_start,
//            |     |        window_end
//
// One request at a time runs through a control sequence around a single-port
// sample RAM. A rejected or empty request goes from the check to the result;
// a read finds its slot and reads it when the frame is in the window, a write
// finds its slot and writes it; a first write frame also moves the window and
// zeroes each slot it skips past the window end (at most CAPACITY). With a
// capacity that is not a power of two the iterative remainder unit finds slots.
// After reset a clearing pass writes zeros to all CAPACITY slots, one a cycle,
// with s_axis_tready low. A result waits in the output register while the
// next request is accepted; a stalled output only holds the final step.
// Depends on tarb_pkg, tarb_ram and tarb_mod.
module timestamped_audio_ring_buffer
    import tarb_pkg::*;
#(
    parameter int CAPACITY    = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [47:0] request_start, [60:48] request_frames, [72:61] frame_index,
    // [104:73] chan0_sample, [136:105] chan1_sample, [143:137] zero
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] ok, [1] in_window, [33:2] chan0_out, [65:34] chan1_out,
    // [113:66] window_start, [161:114] window_end, [167:162] zero
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = 2 * SAMPLE_BITS;
    localparam logic [TIME_BITS-1:0] CAP_T = TIME_BITS'(CAPACITY);
    localparam logic [TIME_BITS:0]   CAP_L = (TIME_BITS + 1)'(CAPACITY);
    localparam logic [AW-1:0]        LAST_SLOT = AW'(CAPACITY - 1);

    t_state r_state;

    // Request held for the whole sequence
    logic                   r_cmd;
    logic [TIME_BITS-1:0]   r_rstart;
    logic [FRAMES_BITS-1:0] r_frames;
    logic [INDEX_BITS-1:0]  r_idx;
    logic [SAMPLE_BITS-1:0] r_s0;
    logic [SAMPLE_BITS-1:0] r_s1;

    // Working values
    logic [TIME_BITS-1:0]   r_t;
    logic [TIME_BITS-1:0]   r_wend;
    logic [TIME_BITS-1:0]   r_ns;
    logic [TIME_BITS-1:0]   r_span;
    logic                   r_before;
    logic [AW-1:0]          r_slot;
    logic [AW-1:0]          r_gap_slot;
    logic [CW-1:0]          r_gap_cnt;
    logic [AW-1:0]          r_clr_addr;

    // Window
    logic [TIME_BITS-1:0]   r_start;
    logic [TIME_BITS-1:0]   r_end;

    // Result under construction
    logic                   r_res_ok;
    logic                   r_res_inw;
    logic [SAMPLE_BITS-1:0] r_res_c0;
    logic [SAMPLE_BITS-1:0] r_res_c1;

    // Output register
    logic                        r_out_valid;
    logic                        r_out_ok;
    logic                        r_out_inw;
    logic [PORT_SAMPLE_BITS-1:0] r_out_c0;
    logic [PORT_SAMPLE_BITS-1:0] r_out_c1;
    logic [TIME_BITS-1:0]        r_out_wstart;
    logic [TIME_BITS-1:0]        r_out_wend;

    // Combinational helpers
    logic [TIME_BITS:0]   sum_end;
    logic                 req_valid;
    logic [TIME_BITS-1:0] t_next;
    logic [TIME_BITS-1:0] gap;
    logic                 in_win;
    logic                 out_load;

    logic                 mod_start;
    logic [TIME_BITS-1:0] mod_value;
    logic                 mod_done;
    logic [AW-1:0]        mod_rem;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_addr;
    logic [DW-1:0]        ram_wdata;
    logic [DW-1:0]        ram_rdata;

    assign s_axis_tready = (r_state == S_IDLE);

    // Request checks: nonzero length within capacity, end inside the time range,
    // frame inside its request.
    assign sum_end   = {1'b0, r_rstart} + (TIME_BITS + 1)'(r_frames);
    assign req_valid = (r_frames != '0) && ((TIME_BITS + 1)'(r_frames) <= CAP_L)
                       && !sum_end[TIME_BITS]
                       && (FRAMES_BITS'(r_idx) < r_frames);
    assign t_next    = r_rstart + TIME_BITS'(r_idx);
    assign gap       = r_rstart - r_end;
    assign in_win    = (r_t >= r_start) && (r_t < r_end);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // One remainder unit, shared by the frame slot and the gap start slot.
    always_comb begin
        mod_start = 1'b0;
        mod_value = r_end;
        case (r_state)
            S_CHECK: begin
                mod_start = req_valid;
                mod_value = t_next;
            end
            S_GAPCK: begin
                mod_start = (r_rstart > r_end);
                mod_value = r_end;
            end
            default: begin
                mod_start = 1'b0;
                mod_value = r_end;
            end
        endcase
    end

    tarb_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // RAM port: clearing pass, gap zeroing, sample write, sample read.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_slot;
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_addr;
            end
            S_ZERO: begin
                ram_we   = 1'b1;
                ram_addr = r_gap_slot;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = {r_s1, r_s0};
            end
            S_READ: begin
                ram_re = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tarb_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    // Sweep every slot to zero before the first request
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Reject or skip straight to the result, else find the slot
                    r_state <= req_valid ? S_MODT : S_DONE;
                end
                S_MODT: begin
                    if (mod_done) begin
                        if (r_cmd == CMD_READ) begin
                            r_state <= in_win ? S_READ : S_DONE;
                        end else if (r_idx == '0) begin
                            r_state <= S_BND1;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_state <= S_DONE;
                end
                S_BND1: begin
                    r_state <= S_BND2;
                end
                S_BND2: begin
                    // Restart the window for a write before its end, else
                    // advance its start when the span would pass capacity
                    if (r_before) begin
                        r_start <= r_rstart;
                        r_end   <= r_rstart;
                    end else if (r_span > CAP_T) begin
                        r_start <= r_ns;
                        if (r_ns > r_end) begin
                            r_end <= r_ns;
                        end
                    end
                    r_state <= S_GAPCK;
                end
                S_GAPCK: begin
                    r_state <= (r_rstart > r_end) ? S_MODG : S_WRITE;
                end
                S_MODG: begin
                    if (mod_done) begin
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (r_gap_cnt == CW'(1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    // Frame zero of a write moves the window end to the request end
                    if (r_idx == '0) begin
                        r_end <= r_wend;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd    <= s_axis_tuser;
            r_rstart <= s_axis_tdata[47:0];
            r_frames <= s_axis_tdata[60:48];
            r_idx    <= s_axis_tdata[72:61];
            r_s0     <= s_axis_tdata[73 +: SAMPLE_BITS];
            r_s1     <= s_axis_tdata[105 +: SAMPLE_BITS];
        end

        case (r_state)
            S_CHECK: begin
                r_t       <= t_next;
                r_wend    <= sum_end[TIME_BITS-1:0];
                r_res_ok  <= (r_frames == '0) || req_valid;
                r_res_inw <= 1'b0;
                r_res_c0  <= '0;
                r_res_c1  <= '0;
            end
            S_MODT: begin
                if (mod_done) begin
                    r_slot    <= mod_rem;
                    r_res_inw <= (r_cmd == CMD_READ) && in_win;
                end
            end
            S_RDATA: begin
                r_res_c0 <= ram_rdata[SAMPLE_BITS-1:0];
                r_res_c1 <= ram_rdata[DW-1:SAMPLE_BITS];
            end
            S_BND1: begin
                r_before <= (r_rstart < r_end);
                r_span   <= r_wend - r_start;
                r_ns     <= r_wend - CAP_T;
            end
            S_GAPCK: begin
                // Zero at most one full turn of the ring
                r_gap_cnt <= (gap > CAP_T) ? CW'(CAPACITY) : gap[CW-1:0];
            end
            S_MODG: begin
                if (mod_done) begin
                    r_gap_slot <= mod_rem;
                end
            end
            S_ZERO: begin
                r_gap_slot <= (r_gap_slot == LAST_SLOT) ? '0 : r_gap_slot + 1'b1;
                r_gap_cnt  <= r_gap_cnt - 1'b1;
            end
            default: begin
                r_t <= r_t;
            end
        endcase

        if (out_load) begin
            r_out_ok     <= r_res_ok;
            r_out_inw    <= r_res_inw;
            r_out_c0     <= PORT_SAMPLE_BITS'(r_res_c0);
            r_out_c1     <= PORT_SAMPLE_BITS'(r_res_c1);
            r_out_wstart <= r_start;
            r_out_wend   <= r_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, r_out_wend, r_out_wstart,
                            r_out_c1, r_out_c0, r_out_inw, r_out_ok};

endmodule

@@ rtl/core/tarb_chk.sv @@
// Port-level checker for the timestamped audio frame store, bound to the top.
// Depends on tarb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tarb_chk
    import tarb_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_m_tvalid,
    input logic                      i_m_tready,
    input logic [OUT_TDATA_BITS-1:0] i_m_tdata
);

    logic                        ok;
    logic                        inw;
    logic [PORT_SAMPLE_BITS-1:0] c0;
    logic [PORT_SAMPLE_BITS-1:0] c1;
    logic [TIME_BITS-1:0]        wstart;
    logic [TIME_BITS-1:0]        wend;

    assign ok     = i_m_tdata[0];
    assign inw    = i_m_tdata[1];
    assign c0     = i_m_tdata[33:2];
    assign c1     = i_m_tdata[65:34];
    assign wstart = i_m_tdata[113:66];
    assign wend   = i_m_tdata[161:114];

    // A rejected request never reports a frame inside the window
    `ASSERT_IMP(a_reject_outside, i_clk, i_rst_n, i_m_tvalid && !ok, !inw)

    // Samples outside the window read as zero
    `ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, i_m_tvalid && !inw, c0 == '0 && c1 == '0)

    // The window is ordered and never spans more than the ring
    `ASSERT_IMP(a_window_span, i_clk, i_rst_n, i_m_tvalid, wstart <= wend && (wend - wstart) <= TIME_BITS'(CAPACITY))

    // A stalled result holds
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

endmodule

bind timestamped_audio_ring_buffer tarb_chk #(
    .CAPACITY (CAPACITY)
) u_tarb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

@@ sim/timestamped_audio_ring_buffer_tb.sv @@
// Self-checking bench for the timestamped audio frame store: directed rows, then
// random write and read requests, each checked against its row or a frame-time model.
// Depends on tarb_pkg and the timestamped_audio_ring_buffer RTL.
module timestamped_audio_ring_buffer_tb;
    import tarb_pkg::*;

    localparam longint unsigned RING_SLOTS = 4096;
    localparam longint unsigned TIME_MASK  = 64'h0000_FFFF_FFFF_FFFF;
    localparam int              QUIET_LIMIT = 30000;  // clearing pass plus a full gap fill, several times
    localparam int              LONG_HOLD   = 400;
    localparam int              DRAIN_CYCLES = 64;
    localparam int              TARGET_FRAMES = 1000;

    typedef struct packed {
        logic                        cmd;
        logic [TIME_BITS-1:0]        rstart;
        logic [FRAMES_BITS-1:0]      frames;
        logic [INDEX_BITS-1:0]       idx;
        logic [PORT_SAMPLE_BITS-1:0] s0;
        logic [PORT_SAMPLE_BITS-1:0] s1;
    } frame_stim_t;

    typedef struct packed {
        logic                        ok;
        logic                        in_win;
        logic [PORT_SAMPLE_BITS-1:0] c0;
        logic [PORT_SAMPLE_BITS-1:0] c1;
        logic [TIME_BITS-1:0]        ws;
        logic [TIME_BITS-1:0]        we;
    } frame_result_t;

    typedef struct {
        frame_stim_t   stim;
        bit            typed;
        frame_result_t res;
    } frame_row_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    // Model of the store: sample slots, and the valid time window [win_start, win_end).
    logic [PORT_SAMPLE_BITS-1:0] ring_c0 [RING_SLOTS];
    logic [PORT_SAMPLE_BITS-1:0] ring_c1 [RING_SLOTS];
    longint unsigned             win_start;
    longint unsigned             win_end;

    frame_result_t pending_results [$];
    frame_row_t    directed_rows [$];

    int  mismatches;
    int  frames_offered;
    int  results_seen;
    int  reads_in_window;
    int  rejects_seen;
    bit  calm;          // last stretch of the run: no idling on either side
    bit  src_bursty;
    bit  hold_sink;
    bit  sink_held;

    timestamped_audio_ring_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Advance the model by one accepted frame request and return what the block must answer.
    function automatic frame_result_t frame_store_step(input frame_stim_t st);
        frame_result_t   r;
        longint unsigned req_lo;
        longint unsigned req_hi;
        longint unsigned t;
        longint unsigned gap;
        longint unsigned k;
        int unsigned     slot;
        r = '0;
        req_lo = st.rstart;
        req_hi = req_lo + st.frames;
        if (st.frames == 0) begin
            r.ok = 1'b1;
        end else if (st.frames <= RING_SLOTS && req_hi <= TIME_MASK && st.idx < st.frames) begin
            r.ok = 1'b1;
            t = req_lo + st.idx;
            slot = t % RING_SLOTS;
            if (st.cmd == CMD_WRITE) begin
                // Frame zero moves the window for the whole request.
                if (st.idx == 0) begin
                    if (req_lo < win_end) begin
                        win_start = req_lo;
                        win_end = req_lo;
                    end else if (req_hi - win_start > RING_SLOTS) begin
                        win_start = req_hi - RING_SLOTS;
                        if (win_start > win_end) begin
                            win_end = win_start;
                        end
                    end
                    // Clear the slots skipped over, never more than one lap.
                    if (req_lo > win_end) begin
                        gap = req_lo - win_end;
                        if (gap > RING_SLOTS) begin
                            gap = RING_SLOTS;
                        end
                        for (k = 0; k < gap; k++) begin
                            ring_c0[(win_end + k) % RING_SLOTS] = '0;
                            ring_c1[(win_end + k) % RING_SLOTS] = '0;
                        end
                    end
                    win_end = req_hi;
                end
                ring_c0[slot] = st.s0;
                ring_c1[slot] = st.s1;
            end else if (t >= win_start && t < win_end) begin
                r.in_win = 1'b1;
                r.c0 = ring_c0[slot];
                r.c1 = ring_c1[slot];
            end
        end
        r.ws = win_start[TIME_BITS-1:0];
        r.we = win_end[TIME_BITS-1:0];
        return r;
    endfunction

    // Add a directed row; when typed, only ok and the window are given, the rest is zero.
    function automatic void add_row(input logic cmd, input longint unsigned rstart,
                                    input int frames, input int idx,
                                    input logic [31:0] s0, input logic [31:0] s1,
                                    input bit typed, input logic ok,
                                    input longint unsigned ws, input longint unsigned we);
        frame_row_t row;
        row.stim = '{cmd, rstart[TIME_BITS-1:0], frames[FRAMES_BITS-1:0],
                     idx[INDEX_BITS-1:0], s0, s1};
        row.typed = typed;
        row.res = '{ok, 1'b0, '0, '0, ws[TIME_BITS-1:0], we[TIME_BITS-1:0]};
        directed_rows.push_back(row);
    endfunction

    // Offer one frame request at the falling edge, hold it until accepted, then queue
    // its expected result. A random short gap may follow.
    task automatic offer_frame(input frame_stim_t st, input bit typed,
                               input frame_result_t typed_res);
        frame_result_t predicted;
        s_axis_tdata  = {{(IN_TDATA_BITS - 137){1'b0}}, st.s1, st.s0, st.idx,
                         st.frames, st.rstart};
        s_axis_tuser  = st.cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = frame_store_step(st);
        pending_results.push_back(typed ? typed_res : predicted);
        frames_offered++;
        @(negedge i_clk);
        if (!calm && src_bursty && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: reset, directed rows, then random request sequences.
    initial begin : source
        frame_stim_t     st;
        frame_result_t   none;
        longint unsigned base;
        longint unsigned span;
        int              kind;
        int              nframes;
        int              nsend;
        int              k;
        bit              skip_first;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        frames_offered = 0;
        results_seen = 0;
        reads_in_window = 0;
        rejects_seen = 0;
        calm = 1'b0;
        src_bursty = 1'b0;
        hold_sink = 1'b0;
        sink_held = 1'b0;
        none = '0;
        win_start = 0;
        win_end = 0;
        for (k = 0; k < RING_SLOTS; k++) begin
            ring_c0[k] = '0;
            ring_c1[k] = '0;
        end

        // After reset: an empty window, then each rejection leaves it untouched.
        add_row(CMD_READ,  0, 1, 0, '0, '0, 1, 1'b1, 0, 0);
        add_row(CMD_WRITE, 0, 0, 0, '1, '1, 1, 1'b1, 0, 0);             // zero-length
        add_row(CMD_WRITE, 0, 4097, 0, '1, '1, 1, 1'b0, 0, 0);          // longer than the ring
        add_row(CMD_READ,  0, 8191, 4095, '0, '0, 1, 1'b0, 0, 0);
        add_row(CMD_WRITE, TIME_MASK, 1, 0, '1, '1, 1, 1'b0, 0, 0);     // runs off the time range
        add_row(CMD_READ,  TIME_MASK - 1, 2, 1, '0, '0, 1, 1'b0, 0, 0);
        add_row(CMD_WRITE, 0, 3, 3, '1, '1, 1, 1'b0, 0, 0);             // index beyond request
        add_row(CMD_WRITE, 0, 4, 0, '1, '0, 1, 1'b1, 0, 4);
        add_row(CMD_WRITE, 0, 4, 1, '0, '1, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  0, 4, 0, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  0, 4, 1, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  0, 4, 3, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  4, 1, 0, '0, '0, 0, 1'b0, 0, 0);             // just past the end
        add_row(CMD_WRITE, 2, 2, 0, 32'h1234_5678, 32'h9abc_def0, 0, 1'b0, 0, 0); // restart
        add_row(CMD_READ,  0, 3, 1, '0, '0, 0, 1'b0, 0, 0);             // before the start
        add_row(CMD_READ,  0, 4, 2, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_WRITE, 10, 2, 0, 32'h0bad_f00d, 32'hcafe_0001, 0, 1'b0, 0, 0); // gap fill
        add_row(CMD_READ,  4, 8, 5, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_WRITE, 100, 4096, 4095, 32'h8000_0001, 32'h7fff_fffe, 0, 1'b0, 0, 0);
        add_row(CMD_WRITE, 100, 4096, 0, 32'h5555_aaaa, 32'haaaa_5555, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  100, 4096, 4095, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_WRITE, TIME_MASK - 1, 1, 0, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  TIME_MASK - 1, 1, 0, '0, '0, 0, 1'b0, 0, 0);
        add_row(CMD_WRITE, 0, 1, 0, 32'h0000_0001, 32'h8000_0000, 0, 1'b0, 0, 0);
        add_row(CMD_READ,  0, 1, 0, '0, '0, 0, 1'b0, 0, 0);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            offer_frame(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].res);
        end

        while (frames_offered < TARGET_FRAMES) begin
            src_bursty = $urandom_range(0, 1);
            if (frames_offered > TARGET_FRAMES - 100) begin
                calm = 1'b1;
            end
            if (!sink_held && frames_offered > 300) begin
                hold_sink = 1'b1;   // sink stops for a long while; keep offering
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // Write request: mostly contiguous, some gaps, some rewinds, a few far jumps.
                k = $urandom_range(0, 99);
                if (k < 60) begin
                    base = win_end;
                end else if (k < 80) begin
                    base = win_end + $urandom_range(1, 24);
                end else if (k < 94) begin
                    span = win_end - win_start;
                    base = win_start + ((span == 0) ? 0 : ($urandom % (span < 30 ? span : 30)));
                end else begin
                    base = {$urandom, $urandom} & TIME_MASK;
                end
                nframes = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                       : $urandom_range(13, 4096);
                nsend = (nframes < 12) ? nframes : $urandom_range(1, 12);
                skip_first = ($urandom_range(0, 9) == 0);   // broken sequence: no frame zero
                for (k = skip_first; k < nsend; k++) begin
                    st.cmd = CMD_WRITE;
                    st.rstart = base[TIME_BITS-1:0];
                    st.frames = nframes;
                    st.idx = (k > 0 && nframes > nsend && $urandom_range(0, 2) == 0)
                             ? $urandom_range(1, nframes - 1) : k;
                    st.s0 = pick_sample();
                    st.s1 = pick_sample();
                    offer_frame(st, 0, none);
                end
            end else if (kind < 85) begin
                // Read request straddling the window edges or inside it.
                k = $urandom_range(0, 2);
                base = (k == 0) ? win_start : win_end;
                if (k == 2) begin
                    span = win_end - win_start;
                    base = win_start + ((span == 0) ? 0 : ($urandom % span));
                end
                span = $urandom_range(0, 6);
                base = ((base > span) ? base - span : 0) + $urandom_range(0, 6);
                nframes = $urandom_range(1, 12);
                for (k = 0; k < nframes; k++) begin
                    st = '{CMD_READ, base[TIME_BITS-1:0], nframes[FRAMES_BITS-1:0],
                           k[INDEX_BITS-1:0], pick_sample(), pick_sample()};
                    offer_frame(st, 0, none);
                end
            end else begin
                // Noise: random fields, often rejected; some near the top of the time range.
                st.cmd = $urandom_range(0, 1);
                base = {$urandom, $urandom} & TIME_MASK;
                if ($urandom_range(0, 1) == 0) begin
                    base = TIME_MASK - $urandom_range(0, 8192);
                end
                st.rstart = base[TIME_BITS-1:0];
                st.frames = $urandom;
                st.idx = $urandom;
                if (st.cmd == CMD_WRITE && st.idx == 0) begin
                    st.idx = 1;     // keep noise from moving the window
                end
                st.s0 = $urandom;
                st.s1 = $urandom;
                offer_frame(st, 0, none);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d frame requests, %0d results: %0d reads inside the window, %0d rejects.",
                 frames_offered, results_seen, reads_in_window, rejects_seen);
        if (mismatches == 0) begin
            $display("timestamped_audio_ring_buffer_tb: PASS");
        end else begin
            $display("timestamped_audio_ring_buffer_tb: FAIL");
        end
        $finish;
    end

    // Result sink: short random stalls, one long hold-off, and none at the end.
    initial begin : sink
        int cyc;
        bit sink_bursty;
        cyc = 0;
        sink_bursty = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 48 == 0) begin
                sink_bursty = $urandom_range(0, 1);
            end
            if (hold_sink && !sink_held) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                sink_held = 1'b1;
            end else if (!calm && sink_bursty && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // Compare each delivered result with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        frame_result_t got;
        frame_result_t want;
        got = m_axis_tdata[OUT_FIELD_BITS-1:0];
        got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[33:2], m_axis_tdata[65:34],
                m_axis_tdata[113:66], m_axis_tdata[161:114]};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %p", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (want.in_win) begin
                    reads_in_window++;
                end
                if (!want.ok) begin
                    rejects_seen++;
                end
                if (got.ok !== want.ok) begin
                    mismatches++;
                    $display("%0t: ok expected %0b got %0b", $time, want.ok, got.ok);
                end
                if (got.in_win !== want.in_win) begin
                    mismatches++;
                    $display("%0t: in_window expected %0b got %0b", $time, want.in_win, got.in_win);
                end
                if (got.c0 !== want.c0) begin
                    mismatches++;
                    $display("%0t: chan0_out expected %h got %h", $time, want.c0, got.c0);
                end
                if (got.c1 !== want.c1) begin
                    mismatches++;
                    $display("%0t: chan1_out expected %h got %h", $time, want.c1, got.c1);
                end
                if (got.ws !== want.ws) begin
                    mismatches++;
                    $display("%0t: window_start expected %h got %h", $time, want.ws, got.ws);
                end
                if (got.we !== want.we) begin
                    mismatches++;
                    $display("%0t: window_end expected %h got %h", $time, want.we, got.we);
                end
            end
        end
    end

    // Abort if neither side moves a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("timestamped_audio_ring_buffer_tb: FAIL");
        $finish;
    end

endmodule
